FILE: hw/rtl/stprng64_pkg.sv
package stprng64_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned HalfW     = 32;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned RoundCntW = 3;
  localparam int unsigned InBytesW  = 8;

  localparam logic [WordW-1:0] TfOrConst = 64'h0000_0000_4000_0005;

  localparam int unsigned RotA   = 25;
  localparam int unsigned RotC   = 19;
  localparam int unsigned RotD   = 51;
  localparam int unsigned RotOut = 47;

  // A reseed runs three warm-up rounds after the first one, then one more
  // round whose first buffer word is the answer.
  localparam logic [RoundCntW-1:0] ReseedExtraRounds = 3'd4;

  localparam logic [IdxW-1:0] IdxForceMix = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSeedA = 2'd0,
    CfgSeedB = 2'd1,
    CfgSeedC = 2'd2,
    CfgSeedD = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StMulLo,
    StMulCross,
    StSqSum,
    StUpdate,
    StFill,
    StEmit
  } state_e;

  typedef struct packed {
    logic load_seeds;
    logic mul_lo;
    logic mul_cross;
    logic sq_sum;
    logic update;
    logic fill;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic idx_high;
  } dp_status_t;

endpackage

FILE: hw/rtl/stprng64_dp.sv
module stprng64_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [stprng64_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [stprng64_pkg::WordW-1:0]      cfg_data_i,
  input  stprng64_pkg::dp_cmd_t               cmd_i,
  output stprng64_pkg::dp_status_t            status_o,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [stprng64_pkg::WordW-1:0]      m_tdata_o
);
  import stprng64_pkg::*;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                            input int unsigned r);
    rotl = (x << r) | (x >> (WordW - r));
  endfunction

  logic [WordW-1:0] seed_a_q, seed_b_q, seed_c_q, seed_d_q;
  logic [WordW-1:0] word_a_q, word_b_q, word_c_q, word_d_q;
  logic [WordW-1:0] word_a_d, word_b_d, word_c_d, word_d_d;
  logic [WordW-1:0] mix_t;
  logic [WordW-1:0] buf_q [4];
  logic [IdxW-1:0]  idx_q;
  logic [WordW-1:0] out_data_q;
  logic             out_valid_q;

  logic [HalfW-1:0] mul_op_b;
  logic [WordW-1:0] mul_prod;
  logic [WordW-1:0] p_lo_q;
  logic [HalfW-1:0] p_x_q;
  logic [WordW-1:0] sq_q;

  // Seed registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_a_q <= '0;
      seed_b_q <= '0;
      seed_c_q <= '0;
      seed_d_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgSeedA: seed_a_q <= cfg_data_i;
        CfgSeedB: seed_b_q <= cfg_data_i;
        CfgSeedC: seed_c_q <= cfg_data_i;
        CfgSeedD: seed_d_q <= cfg_data_i;
        default:  seed_a_q <= seed_a_q;
      endcase
    end
  end

  // The low 64 bits of b*b are lo*lo + 2*lo*hi*2^32, so one 32x32
  // multiplier used twice covers the square.
  assign mul_op_b = cmd_i.mul_cross ? word_b_q[WordW-1:HalfW] : word_b_q[HalfW-1:0];
  assign mul_prod = {{HalfW{1'b0}}, word_b_q[HalfW-1:0]} * {{HalfW{1'b0}}, mul_op_b};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      p_lo_q <= mul_prod;
    end
    if (cmd_i.mul_cross) begin
      p_x_q <= mul_prod[HalfW-1:0];
    end
    if (cmd_i.sq_sum) begin
      sq_q <= p_lo_q + {p_x_q[HalfW-2:0], {(HalfW+1){1'b0}}};
    end
  end

  always_comb begin
    mix_t    = rotl(word_a_q, RotA) ^ word_b_q;
    word_b_d = word_b_q + (sq_q | TfOrConst);
    word_c_d = rotl(word_c_q, RotC) ^ mix_t;
    word_a_d = rotl(word_d_q, RotD) + mix_t;
    word_d_d = mix_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_a_q <= '0;
      word_b_q <= '0;
      word_c_q <= '0;
      word_d_q <= '0;
    end else if (cmd_i.load_seeds) begin
      word_a_q <= seed_a_q;
      word_b_q <= seed_b_q;
      word_c_q <= seed_c_q;
      word_d_q <= seed_d_q;
    end else if (cmd_i.update) begin
      word_a_q <= word_a_d;
      word_b_q <= word_b_d;
      word_c_q <= word_c_d;
      word_d_q <= word_d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      buf_q[0] <= word_a_q + word_b_q;
      buf_q[1] <= rotl(word_a_q, RotOut) + word_b_q;
      buf_q[2] <= word_c_q + word_d_q;
      buf_q[3] <= rotl(word_c_q, RotOut) + word_d_q;
    end
    if (cmd_i.emit) begin
      out_data_q <= buf_q[idx_q[1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= IdxForceMix;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.fill) begin
        idx_q <= '0;
      end else if (cmd_i.emit) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || m_tready_i;
  assign status_o.idx_high = idx_q[IdxW-1];
  assign m_tvalid_o        = out_valid_q;
  assign m_tdata_o         = out_data_q;

  // A word is only written into the output register when it has room.
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> status_o.out_free)
    else $error("output word overwritten before it was taken");

  // A fresh buffer always hands out its first word next.
  a_fill_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill |=> idx_q == '0)
    else $error("buffer position not restarted after a round");

  // A waiting word keeps its value until the receiver takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(m_tdata_o)))
    else $error("output word dropped or changed while stalled");

endmodule

FILE: hw/rtl/stprng64_ctrl.sv
module stprng64_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  input  logic                      reseed_i,
  output logic                      s_tready_o,
  input  stprng64_pkg::dp_status_t  status_i,
  output stprng64_pkg::dp_cmd_t     cmd_o
);
  import stprng64_pkg::*;

  state_e                 state_q, state_d;
  logic [RoundCntW-1:0]   rounds_q, rounds_d;
  logic                   accept;

  assign s_tready_o = (state_q == StIdle) && status_i.out_free;
  assign accept     = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rounds_q <= '0;
    end else begin
      state_q  <= state_d;
      rounds_q <= rounds_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    rounds_d = rounds_q;
    case (state_q)
      StIdle: begin
        if (accept && reseed_i) begin
          state_d  = StLoad;
          rounds_d = ReseedExtraRounds;
        end else if (accept && status_i.idx_high) begin
          state_d  = StMulLo;
          rounds_d = '0;
        end
      end
      StLoad:     state_d = StMulLo;
      StMulLo:    state_d = StMulCross;
      StMulCross: state_d = StSqSum;
      StSqSum:    state_d = StUpdate;
      StUpdate:   state_d = StFill;
      StFill: begin
        if (rounds_q != '0) begin
          state_d  = StMulLo;
          rounds_d = rounds_q - 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle:     cmd_o.emit = accept && !reseed_i && !status_i.idx_high;
      StLoad:     cmd_o.load_seeds = 1'b1;
      StMulLo:    cmd_o.mul_lo = 1'b1;
      StMulCross: cmd_o.mul_cross = 1'b1;
      StSqSum:    cmd_o.sq_sum = 1'b1;
      StUpdate:   cmd_o.update = 1'b1;
      StFill:     cmd_o.fill = 1'b1;
      StEmit:     cmd_o.emit = status_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_tready_o)
    else $error("input accepted while a request is in progress");

  a_rounds_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rounds_q <= ReseedExtraRounds)
    else $error("round counter out of range");

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && status_i.out_free) |=> state_q == StIdle)
    else $error("controller did not return to idle after its word");

endmodule

FILE: hw/rtl/scrambled_tfunction_prng64_core.sv
// Channel   Dir  Signals                                  Word contents
// s_axis    in   s_axis_tvalid/tready/tdata[7:0]          bit 0 reseed, bits 7:1 zero
// m_axis    out  m_axis_tvalid/tready/tdata[63:0]         random_word
// cfg       in   cfg_valid_i/cfg_ready_o/index/data       seed_a..seed_d at index 0..3
//
// Three of every four plain requests are answered from the output buffer in the cycle after
// the word is accepted. The fourth runs a mixer round: the shared 32x32 multiplier squares
// word b in two passes, then come a sum, the update and the buffer fill; the first new word
// leaves when the output register has room. A reseed runs a seed load and five mixer rounds.
// After reset the position stands at four, so the first request runs a round.
// The input is taken only while the controller is idle and the output register has room.
module scrambled_tfunction_prng64_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [stprng64_pkg::InBytesW-1:0]   s_axis_tdata,   // [0] reseed
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [stprng64_pkg::WordW-1:0]      m_axis_tdata,   // [63:0] random_word
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [stprng64_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [stprng64_pkg::WordW-1:0]      cfg_data_i
);
  import stprng64_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  stprng64_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .reseed_i   (s_axis_tdata[0]),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  stprng64_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule
